// ===== sv/csseq_pkg.sv =====
// Shared types, constants and chord tables for the chord step sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
package csseq_pkg;

   localparam int MAX_STEPS  = 8;
   localparam int MAX_TONES  = 4;
   localparam int STEP_LIMIT = (MAX_STEPS < 8) ? MAX_STEPS : 8;
   localparam int IDX_W      = $clog2(MAX_TONES + 1);
   localparam int TONE_W     = $clog2(MAX_TONES);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 56;

   localparam logic [CSR_IDX_W-1:0] CFG_STEP_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_STEP_CHORDS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_BASE_OCTAVE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_BEATS_PER_STEP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_GATE_FRACTION  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_NOTE_VELOCITY  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_CHANNEL_INDEX  = 3'd6;

   localparam logic [7:0] EMPTY_NOTE = 8'hFF;
   localparam logic [2:0] TYPE_MAX   = 3'd6;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_ON     = 2'd1,
      KIND_OFF    = 2'd2
   } kind_type;

   localparam logic [3:0] CHORD_TONES [7][4] = '{
      '{4'd0, 4'd4, 4'd7, 4'd0},
      '{4'd0, 4'd3, 4'd7, 4'd0},
      '{4'd0, 4'd3, 4'd6, 4'd0},
      '{4'd0, 4'd4, 4'd8, 4'd0},
      '{4'd0, 4'd4, 4'd7, 4'd10},
      '{4'd0, 4'd3, 4'd7, 4'd10},
      '{4'd0, 4'd4, 4'd7, 4'd11}
   };

   localparam logic [2:0] CHORD_TONE_COUNT [7] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4};

   typedef struct packed {
      logic     load;
      logic     step;
      logic     chord;
      logic     clr_idx;
      logic     inc_idx;
      logic     emit;
      kind_type emit_kind;
      logic     emit_last;
      logic     drop_held;
      logic     keep_note;
      logic     zero_count;
      logic     set_count;
   } cmd_type;

   typedef struct packed {
      logic rise;
      logic fall;
      logic off_done;
      logic on_done;
      logic held_valid;
      logic out_free;
   } sts_type;

endpackage

// ===== sv/csseq_ctrl.sv =====
// Tick sequencer: walks each item through step update, chord lookup,
// note-offs, note-ons and the closing status. Depends on csseq_pkg.
module csseq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  csseq_pkg::sts_type sts,
   output csseq_pkg::cmd_type cmd
);
   import csseq_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_STEP  = 6'b000010,
      ST_CHORD = 6'b000100,
      ST_OFF   = 6'b001000,
      ST_ON    = 6'b010000,
      ST_STAT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.emit_kind = KIND_STATUS;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_CHORD;
         end
         ST_CHORD: begin
            cmd.chord   = 1'b1;
            cmd.clr_idx = 1'b1;
            state_in    = ST_OFF;
         end
         ST_OFF: begin
            priority if (sts.off_done) begin
               cmd.clr_idx = 1'b1;
               if (sts.rise) begin
                  state_in = ST_ON;
               end else begin
                  cmd.zero_count = sts.fall;
                  state_in       = ST_STAT;
               end
            end else if (!sts.held_valid) begin
               cmd.inc_idx = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_OFF;
               cmd.drop_held = sts.fall;
               cmd.inc_idx   = 1'b1;
            end else begin
               state_in = ST_OFF;
            end
         end
         ST_ON: begin
            priority if (sts.on_done) begin
               cmd.set_count = 1'b1;
               state_in      = ST_STAT;
            end else if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_ON;
               cmd.keep_note = 1'b1;
               cmd.inc_idx   = 1'b1;
            end else begin
               state_in = ST_ON;
            end
         end
         ST_STAT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_STATUS;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while a tick is in progress");

   a_on_needs_rise: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ON) |-> sts.rise)
      else $error("note-on phase without a rising gate");

   a_status_closes: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_last) |=> req_ready)
      else $error("status item did not end the tick");

endmodule

// ===== sv/csseq_dp.sv =====
// Datapath: configuration registers, beat and step counters, chord lookup,
// held-note store and the result register. Depends on csseq_pkg.
module csseq_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [15:0]                          req_beat_phase,
   input  logic                                 csr_write,
   input  logic [csseq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csseq_pkg::CSR_DATA_W-1:0]     csr_data,
   input  csseq_pkg::cmd_type                   cmd,
   output csseq_pkg::sts_type                   sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_event_kind,
   output logic [6:0]                           rsp_event_note,
   output logic [6:0]                           rsp_event_velocity,
   output logic [3:0]                           rsp_event_channel,
   output logic [2:0]                           rsp_current_step,
   output logic                                 rsp_gate_level,
   output logic [6:0]                           rsp_first_note,
   output logic [2:0]                           rsp_tone_count,
   output logic                                 rsp_last_of_tick
);
   import csseq_pkg::*;

   logic [3:0]  step_count_ff;
   logic [55:0] step_chords_ff;
   logic [2:0]  base_octave_ff;
   logic [4:0]  beats_per_step_ff;
   logic [16:0] gate_fraction_ff;
   logic [6:0]  note_velocity_ff;
   logic [3:0]  channel_index_ff;

   logic [15:0] phase_ff, prev_phase_ff;
   logic [3:0]  beat_ff;
   logic [2:0]  step_ff;
   logic        prev_gate_ff, gate_ff, rise_ff, fall_ff;
   logic [6:0]  first_ff;
   logic [2:0]  tones_ff, type_ff;
   logic [7:0]  held_ff [MAX_TONES];
   logic [2:0]  held_count_ff;
   logic [IDX_W-1:0] idx_ff;

   logic        rsp_valid_ff, rsp_last_ff, rsp_gate_ff;
   logic [1:0]  rsp_kind_ff;
   logic [6:0]  rsp_note_ff, rsp_vel_ff, rsp_first_ff;
   logic [3:0]  rsp_chan_ff;
   logic [2:0]  rsp_step_ff, rsp_tones_ff;

   // step counter
   logic [4:0] bps;
   logic [3:0] cnt;
   logic       drop;
   logic [4:0] beat_next;
   logic [3:0] step_next;

   always_comb begin
      bps = beats_per_step_ff;
      if (bps == 5'd0) bps = 5'd1;
      if (bps > 5'd16) bps = 5'd16;
      cnt = step_count_ff;
      if (cnt == 4'd0) cnt = 4'd1;
      if (cnt > 4'(STEP_LIMIT)) cnt = 4'(STEP_LIMIT);
      drop      = (prev_phase_ff > phase_ff) && ((prev_phase_ff - phase_ff) > 16'd32768);
      beat_next = {1'b0, beat_ff} + 5'd1;
      step_next = {1'b0, step_ff} + 4'd1;
   end

   // chord lookup
   logic [6:0] words [8];
   logic [6:0] word;
   logic [2:0] ctype;
   logic [2:0] csize;
   logic       gate;

   always_comb begin
      for (int s = 0; s < 8; s++) begin
         words[s] = step_chords_ff[7*s +: 7];
      end
      word  = words[step_ff];
      ctype = (word[6:4] > TYPE_MAX) ? TYPE_MAX : word[6:4];
      csize = CHORD_TONE_COUNT[ctype];
      if (csize > 3'(MAX_TONES)) csize = 3'(MAX_TONES);
      gate  = ({1'b0, phase_ff} < gate_fraction_ff);
   end

   logic [TONE_W-1:0] tone_idx;
   logic [7:0]        held_entry;
   logic [7:0]        note_sum;
   logic [6:0]        note_on;

   always_comb begin
      tone_idx   = idx_ff[TONE_W-1:0];
      held_entry = held_ff[tone_idx];
      note_sum   = {1'b0, first_ff} + {4'd0, CHORD_TONES[type_ff][tone_idx]};
      note_on    = (note_sum > 8'd127) ? 7'd127 : note_sum[6:0];
   end

   assign sts.rise       = rise_ff;
   assign sts.fall       = fall_ff;
   assign sts.off_done   = !(rise_ff || fall_ff) || ({1'b0, idx_ff} >= {1'b0, held_count_ff})
                           || (idx_ff >= IDX_W'(MAX_TONES));
   assign sts.on_done    = ({1'b0, idx_ff} >= {1'b0, tones_ff});
   assign sts.held_valid = !held_entry[7];
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff     <= 4'd4;
         step_chords_ff    <= '0;
         base_octave_ff    <= 3'd4;
         beats_per_step_ff <= 5'd4;
         gate_fraction_ff  <= 17'd52429;
         note_velocity_ff  <= 7'd101;
         channel_index_ff  <= 4'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CFG_STEP_COUNT:     step_count_ff     <= csr_data[3:0];
            CFG_STEP_CHORDS:    step_chords_ff    <= csr_data[55:0];
            CFG_BASE_OCTAVE:    base_octave_ff    <= csr_data[2:0];
            CFG_BEATS_PER_STEP: beats_per_step_ff <= csr_data[4:0];
            CFG_GATE_FRACTION:  gate_fraction_ff  <= csr_data[16:0];
            CFG_NOTE_VELOCITY:  note_velocity_ff  <= csr_data[6:0];
            CFG_CHANNEL_INDEX:  channel_index_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= '0;
         beat_ff       <= '0;
         step_ff       <= '0;
         prev_gate_ff  <= 1'b0;
         rise_ff       <= 1'b0;
         fall_ff       <= 1'b0;
         held_count_ff <= '0;
         idx_ff        <= '0;
         for (int i = 0; i < MAX_TONES; i++) begin
            held_ff[i] <= EMPTY_NOTE;
         end
      end else begin
         if (cmd.step) begin
            prev_phase_ff <= phase_ff;
            if (drop) begin
               if (beat_next >= bps) begin
                  beat_ff <= '0;
                  step_ff <= (step_next >= cnt) ? 3'd0 : step_next[2:0];
               end else begin
                  beat_ff <= beat_next[3:0];
               end
            end
         end
         if (cmd.chord) begin
            rise_ff      <= gate && !prev_gate_ff;
            fall_ff      <= !gate && prev_gate_ff;
            prev_gate_ff <= gate;
         end
         priority if (cmd.clr_idx) begin
            idx_ff <= '0;
         end else if (cmd.inc_idx) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end else begin
            idx_ff <= idx_ff;
         end
         if (cmd.drop_held) held_ff[tone_idx] <= EMPTY_NOTE;
         if (cmd.keep_note) held_ff[tone_idx] <= {1'b0, note_on};
         if (cmd.zero_count) held_count_ff <= '0;
         if (cmd.set_count) held_count_ff <= tones_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) phase_ff <= req_beat_phase;
      if (cmd.chord) begin
         gate_ff  <= gate;
         first_ff <= {3'd0, word[3:0]} + 7'(base_octave_ff) * 7'd12;
         tones_ff <= csize;
         type_ff  <= ctype;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff  <= cmd.emit_kind;
         rsp_chan_ff  <= channel_index_ff;
         rsp_step_ff  <= step_ff;
         rsp_gate_ff  <= gate_ff;
         rsp_first_ff <= first_ff;
         rsp_tones_ff <= tones_ff;
         rsp_last_ff  <= cmd.emit_last;
         unique case (cmd.emit_kind)
            KIND_ON: begin
               rsp_note_ff <= note_on;
               rsp_vel_ff  <= note_velocity_ff;
            end
            KIND_OFF: begin
               rsp_note_ff <= held_entry[6:0];
               rsp_vel_ff  <= '0;
            end
            default: begin
               rsp_note_ff <= '0;
               rsp_vel_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_event_note     = rsp_note_ff;
   assign rsp_event_velocity = rsp_vel_ff;
   assign rsp_event_channel  = rsp_chan_ff;
   assign rsp_current_step   = rsp_step_ff;
   assign rsp_gate_level     = rsp_gate_ff;
   assign rsp_first_note     = rsp_first_ff;
   assign rsp_tone_count     = rsp_tones_ff;
   assign rsp_last_of_tick   = rsp_last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= 3'(MAX_TONES))
      else $error("held note count out of range");

   a_off_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_kind == KIND_OFF) |-> !held_entry[7])
      else $error("note-off sent for an empty held entry");

endmodule

// ===== sv/chord_step_sequencer_unit.sv =====
// Top level of the chord step sequencer: ties the tick controller to the datapath.
// Depends on csseq_pkg, csseq_ctrl and csseq_dp.
//
// One item is one beat-phase tick. The block takes one tick at a time: a tick
// passes through accept, step update and chord lookup, then examines each held
// entry in turn (up to four note-offs) and closes that walk, on a rising gate
// sends each note-on (three or four) and closes that walk, and ends with the
// closing status item; a busy result register holds the walk. Each tick
// yields one to nine result items, the last always a status item with
// last_of_tick set. Results leave through an output register, so a new tick
// is accepted while the final status item of the previous one still waits.
// Configuration writes take effect at once and belong between ticks.
module chord_step_sequencer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [15:0]                      req_beat_phase,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_event_kind,
   output logic [6:0]                       rsp_event_note,
   output logic [6:0]                       rsp_event_velocity,
   output logic [3:0]                       rsp_event_channel,
   output logic [2:0]                       rsp_current_step,
   output logic                             rsp_gate_level,
   output logic [6:0]                       rsp_first_note,
   output logic [2:0]                       rsp_tone_count,
   output logic                             rsp_last_of_tick,
   input  logic                             csr_write,
   input  logic [csseq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csseq_pkg::CSR_DATA_W-1:0] csr_data
);
   import csseq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   csseq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   csseq_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_beat_phase     (req_beat_phase),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_event_note     (rsp_event_note),
      .rsp_event_velocity (rsp_event_velocity),
      .rsp_event_channel  (rsp_event_channel),
      .rsp_current_step   (rsp_current_step),
      .rsp_gate_level     (rsp_gate_level),
      .rsp_first_note     (rsp_first_note),
      .rsp_tone_count     (rsp_tone_count),
      .rsp_last_of_tick   (rsp_last_of_tick)
   );

endmodule

// ===== tb/csseq_checker.sv =====
// Event checker for the chord step sequencer: follows register writes and accepted ticks,
// predicts the note-off, note-on and status items of every tick and compares them in order.
// Depends on csseq_pkg.
module csseq_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [15:0]                      req_beat_phase,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [1:0]                       rsp_event_kind,
   input  logic [6:0]                       rsp_event_note,
   input  logic [6:0]                       rsp_event_velocity,
   input  logic [3:0]                       rsp_event_channel,
   input  logic [2:0]                       rsp_current_step,
   input  logic                             rsp_gate_level,
   input  logic [6:0]                       rsp_first_note,
   input  logic [2:0]                       rsp_tone_count,
   input  logic                             rsp_last_of_tick,
   input  logic                             csr_write,
   input  logic [csseq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csseq_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               fail_count,
   output int                               pending_count,
   output int                               event_count
);
   import csseq_pkg::*;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [3:0] channel;
      logic [2:0] step;
      logic       gate;
      logic [6:0] first;
      logic [2:0] tones;
      logic       last;
   } midi_event_type;

   localparam int SEMITONES [7][4] = '{
      '{0, 4, 7, 0}, '{0, 3, 7, 0}, '{0, 3, 6, 0}, '{0, 4, 8, 0},
      '{0, 4, 7, 10}, '{0, 3, 7, 10}, '{0, 4, 7, 11}
   };

   logic [3:0]  pattern_len;
   logic [55:0] pattern_words;
   logic [2:0]  octave;
   logic [4:0]  beats_needed;
   logic [16:0] gate_len;
   logic [6:0]  velocity;
   logic [3:0]  channel;

   logic [15:0] last_phase;
   logic [3:0]  beat_pos;
   logic [2:0]  step_pos;
   logic        gate_was;
   logic [7:0]  sounding [MAX_TONES];
   logic [2:0]  sounding_count;

   midi_event_type awaited_events [$];

   function automatic string show_event(input midi_event_type e);
      return {$sformatf("kind %0d note %0d vel %0d ch %0d step %0d ",
                        e.kind, e.note, e.velocity, e.channel, e.step),
              $sformatf("gate %0d first %0d tones %0d last %0d",
                        e.gate, e.first, e.tones, e.last)};
   endfunction

   task automatic queue_event(input kind_type kind, input int note, input int vel,
                              input logic gate, input int first, input int tones,
                              input logic last);
      midi_event_type e;
      e.kind     = kind;
      e.note     = 7'(note);
      e.velocity = 7'(vel);
      e.channel  = channel;
      e.step     = step_pos;
      e.gate     = gate;
      e.first    = 7'(first);
      e.tones    = 3'(tones);
      e.last     = last;
      awaited_events = {awaited_events, e};
   endtask

   task automatic play_tick(input logic [15:0] phase);
      int bps, cnt, word, root, ctype, tones, first, n, i;
      logic gate;
      bps = int'(beats_needed);
      if (bps < 1) bps = 1;
      if (bps > 16) bps = 16;
      cnt = int'(pattern_len);
      if (cnt < 1) cnt = 1;
      if (cnt > STEP_LIMIT) cnt = STEP_LIMIT;

      if (int'(last_phase) - int'(phase) > 32768) begin
         if (int'(beat_pos) + 1 >= bps) begin
            beat_pos = '0;
            step_pos = (int'(step_pos) + 1 >= cnt) ? 3'd0 : step_pos + 3'd1;
         end else begin
            beat_pos = beat_pos + 4'd1;
         end
      end
      last_phase = phase;

      word  = int'((pattern_words >> (7 * int'(step_pos))) & 56'h7F);
      root  = word & 15;
      ctype = (word >> 4) & 7;
      if (ctype > 6) ctype = 6;
      tones = (ctype >= 4) ? 4 : 3;
      if (tones > MAX_TONES) tones = MAX_TONES;
      first = root + int'(octave) * 12;
      gate  = int'(phase) < int'(gate_len);

      if (gate && !gate_was) begin
         for (i = 0; i < int'(sounding_count) && i < MAX_TONES; i++)
            if (sounding[i] < 8'd128)
               queue_event(KIND_OFF, int'(sounding[i]), 0, gate, first, tones, 1'b0);
         for (i = 0; i < tones; i++) begin
            n = first + SEMITONES[ctype][i];
            if (n > 127) n = 127;
            sounding[i] = 8'(n);
            queue_event(KIND_ON, n, int'(velocity), gate, first, tones, 1'b0);
         end
         sounding_count = 3'(tones);
      end else if (!gate && gate_was) begin
         for (i = 0; i < int'(sounding_count) && i < MAX_TONES; i++)
            if (sounding[i] < 8'd128) begin
               queue_event(KIND_OFF, int'(sounding[i]), 0, gate, first, tones, 1'b0);
               sounding[i] = EMPTY_NOTE;
            end
         sounding_count = '0;
      end
      gate_was = gate;
      queue_event(KIND_STATUS, 0, 0, gate, first, tones, 1'b1);
   endtask

   task automatic check_event();
      midi_event_type got, want;
      logic bad;
      got.kind     = kind_type'(rsp_event_kind);
      got.note     = rsp_event_note;
      got.velocity = rsp_event_velocity;
      got.channel  = rsp_event_channel;
      got.step     = rsp_current_step;
      got.gate     = rsp_gate_level;
      got.first    = rsp_first_note;
      got.tones    = rsp_tone_count;
      got.last     = rsp_last_of_tick;
      event_count++;
      if (awaited_events.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected item: %s", show_event(got));
      end else begin
         want = awaited_events.pop_front();
         bad = (got.kind !== want.kind) || (got.note !== want.note) ||
               (got.velocity !== want.velocity) || (got.channel !== want.channel) ||
               (got.step !== want.step) || (got.gate !== want.gate) ||
               (got.first !== want.first) || (got.tones !== want.tones) ||
               (got.last !== want.last);
         if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("mismatch at item %0d", event_count);
               $display("  expected %s", show_event(want));
               $display("  actual   %s", show_event(got));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count     = 0;
         event_count    = 0;
         pattern_len    = 4'd4;
         pattern_words  = '0;
         octave         = 3'd4;
         beats_needed   = 5'd4;
         gate_len       = 17'd52429;
         velocity       = 7'd101;
         channel        = 4'd0;
         last_phase     = '0;
         beat_pos       = '0;
         step_pos       = '0;
         gate_was       = 1'b0;
         sounding_count = '0;
         for (int i = 0; i < MAX_TONES; i++) sounding[i] = EMPTY_NOTE;
         awaited_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_event();
         if (csr_write) begin
            unique case (csr_index)
               CFG_STEP_COUNT:     pattern_len   = csr_data[3:0];
               CFG_STEP_CHORDS:    pattern_words = csr_data[55:0];
               CFG_BASE_OCTAVE:    octave        = csr_data[2:0];
               CFG_BEATS_PER_STEP: beats_needed  = csr_data[4:0];
               CFG_GATE_FRACTION:  gate_len      = csr_data[16:0];
               CFG_NOTE_VELOCITY:  velocity      = csr_data[6:0];
               CFG_CHANNEL_INDEX:  channel       = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) play_tick(req_beat_phase);
      end
      pending_count = awaited_events.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the chord step sequencer: clock, reset, register writes, tick stimulus
// and result-side back-pressure, with the verdict. Depends on csseq_pkg,
// chord_step_sequencer_unit and csseq_checker.
module tb;
   import csseq_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;
   localparam int ROUNDS      = 6;
   localparam int ROUND_TICKS = 31;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [15:0]           req_beat_phase;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_event_kind;
   logic [6:0]            rsp_event_note;
   logic [6:0]            rsp_event_velocity;
   logic [3:0]            rsp_event_channel;
   logic [2:0]            rsp_current_step;
   logic                  rsp_gate_level;
   logic [6:0]            rsp_first_note;
   logic [2:0]            rsp_tone_count;
   logic                  rsp_last_of_tick;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int fail_count;
   int pending_count;
   int event_count;
   int ticks_sent;
   int settings_used;
   bit calm;
   int hold_requests;

   chord_step_sequencer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_beat_phase(req_beat_phase),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_kind(rsp_event_kind), .rsp_event_note(rsp_event_note),
      .rsp_event_velocity(rsp_event_velocity), .rsp_event_channel(rsp_event_channel),
      .rsp_current_step(rsp_current_step), .rsp_gate_level(rsp_gate_level),
      .rsp_first_note(rsp_first_note), .rsp_tone_count(rsp_tone_count),
      .rsp_last_of_tick(rsp_last_of_tick),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   csseq_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_beat_phase(req_beat_phase),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_kind(rsp_event_kind), .rsp_event_note(rsp_event_note),
      .rsp_event_velocity(rsp_event_velocity), .rsp_event_channel(rsp_event_channel),
      .rsp_current_step(rsp_current_step), .rsp_gate_level(rsp_gate_level),
      .rsp_first_note(rsp_first_note), .rsp_tone_count(rsp_tone_count),
      .rsp_last_of_tick(rsp_last_of_tick),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count), .event_count(event_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: random back-pressure, one long hold-off on request
   initial begin
      int n, holds_done;
      holds_done = 0;
      rsp_ready  = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_requests > holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(negedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 23);
            @(negedge clock);
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_tick(input logic [15:0] phase);
      while (!calm && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_beat_phase <= phase;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic req_stop();
      req_valid <= 1'b0;
   endtask

   task automatic settle();
      while (pending_count != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_setting(input int cnt, input logic [55:0] chords, input int oct,
                               input int bps, input int gate, input int vel, input int chan);
      write_reg(CFG_STEP_COUNT, CSR_DATA_W'(cnt));
      write_reg(CFG_STEP_CHORDS, chords);
      write_reg(CFG_BASE_OCTAVE, CSR_DATA_W'(oct));
      write_reg(CFG_BEATS_PER_STEP, CSR_DATA_W'(bps));
      write_reg(CFG_GATE_FRACTION, CSR_DATA_W'(gate));
      write_reg(CFG_NOTE_VELOCITY, CSR_DATA_W'(vel));
      write_reg(CFG_CHANNEL_INDEX, CSR_DATA_W'(chan));
      settings_used++;
   endtask

   initial begin
      logic [55:0] chords;
      int r, i, pick, saw, phase, prev;
      int cnt, bps, gate;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_beat_phase = '0;
      csr_write      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      calm           = 1'b0;
      hold_requests  = 0;
      ticks_sent     = 0;
      settings_used  = 1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: gate edges, exact half drop, one past half
      send_tick(16'd0);     send_tick(16'd60000); send_tick(16'd65535);
      send_tick(16'd32767); send_tick(16'd65535); send_tick(16'd32766);
      req_stop();
      settle();

      // maj7 with chord type 7, top octave, gate always high, steps wrap at three
      chords = 56'({$urandom, $urandom});
      chords[20:0] = {7'h59, 7'h40, 7'h7F};
      load_setting(3, chords, 7, 1, 65536, 127, 15);
      send_tick(16'd0); send_tick(16'd65535); send_tick(16'd0); send_tick(16'd65535);
      send_tick(16'd0); send_tick(16'd65535); send_tick(16'd0);
      req_stop();
      settle();

      // zero step count and beats, gate never high, all-ones pattern
      load_setting(0, {56{1'b1}}, 2, 0, 0, 0, 0);
      send_tick(16'd65535); send_tick(16'd0); send_tick(16'd65535);
      req_stop();
      settle();

      // walk to step three, then shrink the pattern below it
      chords = 56'({$urandom, $urandom});
      load_setting(8, chords, 3, 1, 32768, 64, 9);
      send_tick(16'd65535); send_tick(16'd0); send_tick(16'd65535);
      send_tick(16'd0);     send_tick(16'd65535); send_tick(16'd0);
      req_stop();
      settle();
      write_reg(CFG_STEP_COUNT, CSR_DATA_W'(2));
      send_tick(16'd65535); send_tick(16'd0);
      req_stop();
      settle();

      saw  = 0;
      prev = 0;
      for (r = 0; r < ROUNDS; r++) begin
         chords = 56'({$urandom, $urandom});
         cnt  = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(15);
         bps  = ($urandom_range(99) < 70) ? $urandom_range(3, 1) : $urandom_range(31);
         gate = ($urandom_range(99) < 80) ? $urandom_range(65535) : $urandom_range(131071);
         if (r == 0) begin
            cnt = 15;
            bps = 31;
         end else if (r == ROUNDS - 1) begin
            cnt = 1;
            bps = 1;
         end
         load_setting(cnt, chords, $urandom_range(7), bps, gate, $urandom_range(127),
                      $urandom_range(15));
         calm = (r == 2);
         if (r == 1) hold_requests++;
         for (i = 0; i < ROUND_TICKS; i++) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               saw += $urandom_range(22000, 4000);
               if (saw > 65535) saw -= 65536;
               phase = saw;
            end else if (pick < 80) begin
               phase = (prev >= 32768) ? prev - 32768 : prev;
            end else begin
               phase = $urandom_range(65535);
               saw = phase;
            end
            send_tick(16'(phase));
            prev = phase;
         end
         req_stop();
         settle();
      end
      calm = 1'b0;
      repeat (30) @(negedge clock);

      $display("Ran %0d ticks yielding %0d result items under %0d register settings,",
               ticks_sent, event_count, settings_used);
      $display("including a %0d-cycle result hold-off and a stretch with no idling.",
               HOLD_CYCLES);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
